// ===== sv/assert_macros.svh =====
// Assertion macros used by the renderer datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the property in the same cycle.
`define PSR_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// The condition implies the property in the next cycle.
`define PSR_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/psr_pkg.sv =====
// Types, constants and helper functions of the palette scale-rotate renderer.
`timescale 1ns / 1ps
package psr_pkg;

	localparam int SRC_WIDTH       = 320;
	localparam int SRC_HEIGHT      = 200;
	localparam int PALETTE_ENTRIES = 256;
	localparam int FRAME_SIZE      = SRC_WIDTH * SRC_HEIGHT;

	localparam int FR_AW  = $clog2(FRAME_SIZE);
	localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int SX_W   = $clog2(SRC_WIDTH);
	localparam int SY_W   = $clog2(SRC_HEIGHT);

	localparam int DIM_W   = 11;
	localparam int POS_W   = 10;
	localparam int DIM_MAX = 1024;
	localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
	localparam int NUM_W   = $clog2(DIM_MAX * SRC_MAX + 1);

	// The band height W*SRC_WIDTH/SRC_HEIGHT is a multiply by a rounded-up reciprocal.
	localparam int BAND_SH     = 20;
	localparam int BAND_MUL    = ((SRC_WIDTH << BAND_SH) + SRC_HEIGHT - 1) / SRC_HEIGHT;
	localparam int BAND_MUL_W  = $clog2(BAND_MUL + 1);
	localparam int BAND_PROD_W = DIM_W + BAND_MUL_W;
	localparam int BAND_RAW_W  = BAND_PROD_W - BAND_SH;

	localparam int CMD_W     = 2;
	localparam int ADDR_W    = 16;
	localparam int DATA_W    = 16;
	localparam int PIX_W     = 16;
	localparam int IDX_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_PAL  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIX  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EMIT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd222;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

	typedef enum logic [1:0] {
		DIV_SY,
		DIV_SX
	} psr_div_sel_t;

	typedef struct packed {
		logic         pal_wr;
		logic         frame_wr;
		logic         capture;
		logic         div_start;
		psr_div_sel_t div_sel;
		logic         cap_band;
		logic         cap_sy;
		logic         cap_sx;
		logic         addr_ld;
		logic         frame_rd;
		logic         pal_rd;
		logic         out_load;
	} psr_cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_busy;
		logic mode;
		logic black;
		logic out_free;
	} psr_stat_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (v > DIM_W'(DIM_MAX)) begin
			return DIM_W'(DIM_MAX);
		end
		return v;
	endfunction

endpackage

// ===== sv/psr_if.sv =====
// Valid-ready channel interfaces for request items and display pixels.
`timescale 1ns / 1ps
interface psr_in_if;
	import psr_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] data;
	logic              aspect_mode;

	modport source (output valid, output cmd, output address, output data,
		output aspect_mode, input ready);
	modport sink (input valid, input cmd, input address, input data,
		input aspect_mode, output ready);
endinterface

interface psr_out_if;
	import psr_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic [POS_W-1:0] column;
	logic [POS_W-1:0] row;
	logic             last;

	modport source (output valid, output pixel, output column, output row,
		output last, input ready);
	modport sink (input valid, input pixel, input column, input row,
		input last, output ready);
endinterface

// ===== sv/psr_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module psr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [psr_pkg::NUM_W-1:0] num,
	input  logic [psr_pkg::DIM_W-1:0] den,
	output logic                      busy,
	output logic                      done,
	output logic [psr_pkg::NUM_W-1:0] quo
);
	import psr_pkg::*;

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DIM_W-1:0] den_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W:0]   trial;
	logic [DIM_W:0]   diff;
	logic             ge;
	logic [DIM_W-1:0] rem_d;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};
	assign rem_d = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;

endmodule

// ===== sv/psr_dp.sv =====
// Datapath: stores, counters, coordinate arithmetic and the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psr_pkg::psr_cmd_t             cmd,
	output psr_pkg::psr_stat_t            stat,
	input  logic [psr_pkg::ADDR_W-1:0]    address,
	input  logic [psr_pkg::DATA_W-1:0]    data,
	input  logic                          aspect_mode,
	input  logic                          cfg_write,
	input  logic [psr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psr_pkg::DIM_W-1:0]     cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [psr_pkg::PIX_W-1:0]     pixel,
	output logic [psr_pkg::POS_W-1:0]     column,
	output logic [psr_pkg::POS_W-1:0]     row,
	output logic                          last
);
	import psr_pkg::*;

	logic [IDX_W-1:0] frame_mem [FRAME_SIZE];
	logic [PIX_W-1:0] pal_mem [PALETTE_ENTRIES];

	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic             mode_q;
	logic [POS_W-1:0] cur_c_q;
	logic [POS_W-1:0] cur_r_q;
	logic             last_q;
	logic [DIM_W-1:0] band_q;
	logic [POS_W-1:0] off_q;
	logic [SY_W-1:0]  sy_q;
	logic [SX_W-1:0]  sx_q;
	logic [FR_AW-1:0] fr_addr_s1;
	logic [IDX_W-1:0] idx_q;
	logic [PIX_W-1:0] pal_q;
	logic             idx_ok_q;

	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic [POS_W-1:0] column_q;
	logic [POS_W-1:0] row_q_out;
	logic             last_out_q;

	logic [DIM_W-1:0]       wc;
	logic [DIM_W-1:0]       hc;
	logic [POS_W-1:0]       c_now;
	logic [POS_W-1:0]       r_now;
	logic [DIM_W-1:0]       c_inc;
	logic [DIM_W-1:0]       r_inc;
	logic                   black;
	logic [DIM_W+0:0]       band_end;
	logic [NUM_W-1:0]       div_num;
	logic [DIM_W-1:0]       div_den;
	logic                   div_busy;
	logic                   div_done;
	logic [NUM_W-1:0]       div_quo;
	logic [BAND_PROD_W-1:0] band_prod;
	logic [BAND_RAW_W-1:0]  band_raw;
	logic [DIM_W-1:0]       band_d;
	logic                   pop;

	assign wc = clamp_dim(w_q);
	assign hc = clamp_dim(h_q);

	assign c_now = ({1'b0, col_q} >= wc) ? POS_W'(wc - DIM_W'(1)) : col_q;
	assign r_now = ({1'b0, row_q} >= hc) ? POS_W'(hc - DIM_W'(1)) : row_q;
	assign c_inc = {1'b0, c_now} + DIM_W'(1);
	assign r_inc = {1'b0, r_now} + DIM_W'(1);

	assign band_end = {2'b00, off_q} + {1'b0, band_q};
	assign black = mode_q && ((band_q == '0) || (cur_r_q < off_q)
		|| ({2'b00, cur_r_q} >= band_end));

	always_comb begin
		div_num = '0;
		div_den = wc;
		case (cmd.div_sel)
			DIV_SY: begin
				div_num = NUM_W'((wc - DIM_W'(1) - {1'b0, cur_c_q}) * SRC_HEIGHT);
				div_den = wc;
			end
			DIV_SX: begin
				if (mode_q) begin
					div_num = NUM_W'((cur_r_q - off_q) * SRC_WIDTH);
					div_den = band_q;
				end else begin
					div_num = NUM_W'(cur_r_q * SRC_WIDTH);
					div_den = hc;
				end
			end
			default: begin
				div_num = '0;
				div_den = wc;
			end
		endcase
	end

	psr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign band_prod = BAND_PROD_W'(wc) * BAND_PROD_W'(BAND_MUL);
	assign band_raw  = band_prod[BAND_PROD_W-1:BAND_SH];
	assign band_d    = (band_raw > BAND_RAW_W'(hc)) ? hc : band_raw[DIM_W-1:0];

	// Configuration, frame counters and the mode latched at the first pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WIDTH_RESET;
			h_q    <= HEIGHT_RESET;
			col_q  <= '0;
			row_q  <= '0;
			mode_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WIDTH: begin
					w_q   <= cfg_data;
					col_q <= '0;
					row_q <= '0;
				end
				REG_HEIGHT: begin
					h_q   <= cfg_data;
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.capture) begin
			if (c_now == '0 && r_now == '0) begin
				mode_q <= aspect_mode;
			end
			if (c_inc >= wc) begin
				col_q <= '0;
				row_q <= (r_inc >= hc) ? '0 : r_inc[POS_W-1:0];
			end else begin
				col_q <= c_inc[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_c_q <= c_now;
			cur_r_q <= r_now;
			last_q  <= ({1'b0, c_now} == wc - DIM_W'(1))
				&& ({1'b0, r_now} == hc - DIM_W'(1));
		end
		if (cmd.cap_band) begin
			band_q <= band_d;
			off_q  <= POS_W'((hc - band_d) >> 1);
		end
		if (cmd.cap_sy) begin
			sy_q <= (div_quo >= NUM_W'(SRC_HEIGHT)) ? SY_W'(SRC_HEIGHT - 1)
				: div_quo[SY_W-1:0];
		end
		if (cmd.cap_sx) begin
			sx_q <= (div_quo >= NUM_W'(SRC_WIDTH)) ? SX_W'(SRC_WIDTH - 1)
				: div_quo[SX_W-1:0];
		end
		if (cmd.addr_ld) begin
			fr_addr_s1 <= FR_AW'(sy_q * SRC_WIDTH + sx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_wr && (32'(address) < FRAME_SIZE)) begin
			frame_mem[FR_AW'(address)] <= data[IDX_W-1:0];
		end
		if (cmd.frame_rd) begin
			idx_q <= frame_mem[fr_addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pal_wr && (32'(address) < PALETTE_ENTRIES)) begin
			pal_mem[PAL_AW'(address)] <= data;
		end
		if (cmd.pal_rd) begin
			pal_q    <= pal_mem[PAL_AW'(idx_q)];
			idx_ok_q <= 32'(idx_q) < PALETTE_ENTRIES;
		end
	end

	assign pop = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_q    <= (black || !idx_ok_q) ? '0 : pal_q;
			column_q   <= cur_c_q;
			row_q_out  <= cur_r_q;
			last_out_q <= last_q;
		end
	end

	assign stat.div_done = div_done;
	assign stat.div_busy = div_busy;
	assign stat.mode     = mode_q;
	assign stat.black    = black;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign pixel     = pixel_q;
	assign column    = column_q;
	assign row       = row_q_out;
	assign last      = last_out_q;

	`PSR_ASSERT_NOW(a_load_free, cmd.out_load, !out_valid_q || out_ready, "Output overwritten before its transaction.")
	`PSR_ASSERT_NOW(a_cap_done, cmd.cap_sy || cmd.cap_sx, div_done, "Quotient captured before the divider finished.")
	`PSR_ASSERT_NOW(a_start_idle, cmd.div_start, !div_busy, "Divider restarted while busy.")
	`PSR_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_q, "Loaded pixel not presented.")

endmodule

// ===== sv/psr_ctrl.sv =====
// Controller: sequences writes and the per-pixel divide, fetch and output steps.
`timescale 1ns / 1ps
module psr_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [psr_pkg::CMD_W-1:0] in_cmd,
	output logic                      in_ready,
	input  psr_pkg::psr_stat_t        stat,
	output psr_pkg::psr_cmd_t         cmd
);
	import psr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_BAND_CHK,
		S_SY_WAIT,
		S_SX_WAIT,
		S_ADDR,
		S_FRAME,
		S_PAL,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = DIV_SY;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_PAL: cmd.pal_wr = 1'b1;
						CMD_PIX: cmd.frame_wr = 1'b1;
						CMD_EMIT: begin
							cmd.capture = 1'b1;
							state_d     = S_PREP;
						end
						default: begin
						end
					endcase
				end
			end
			S_PREP: begin
				if (stat.mode) begin
					cmd.cap_band = 1'b1;
					state_d      = S_BAND_CHK;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SY;
					state_d       = S_SY_WAIT;
				end
			end
			S_BAND_CHK: begin
				if (stat.black) begin
					state_d = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SY;
					state_d       = S_SY_WAIT;
				end
			end
			S_SY_WAIT: begin
				if (stat.div_done) begin
					cmd.cap_sy    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SX;
					state_d       = S_SX_WAIT;
				end
			end
			S_SX_WAIT: begin
				cmd.div_sel = DIV_SX;
				if (stat.div_done) begin
					cmd.cap_sx = 1'b1;
					state_d    = S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.addr_ld = 1'b1;
				state_d     = S_FRAME;
			end
			S_FRAME: begin
				cmd.frame_rd = 1'b1;
				state_d      = S_PAL;
			end
			S_PAL: begin
				cmd.pal_rd = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/palette_scale_rotate_renderer.sv =====
// Top level of the palette scale-rotate renderer.
`timescale 1ns / 1ps
// Palette writes and source pixel writes complete as they are accepted. An emit transaction
// produces one RGB565 display pixel, nearest-neighbor scaled from the 320x200 indexed
// frame and rotated clockwise. Off a black bar row, the shared divider resolves one
// quotient bit per cycle and runs once for the source row and once for the source
// column, followed by the registered frame and palette reads; a black bar row skips
// these steps. The aspect band height comes from a reciprocal multiply. A finished
// pixel waits in the output register, and the next transaction is taken while it
// waits; a pixel that finishes while the register is still full holds the input
// until the register is taken. The frame and palette stores hold no reset value and
// must be written before they are read.
module palette_scale_rotate_renderer (
	input  logic                          clk,
	input  logic                          arst_n,
	psr_in_if.sink                        in_ch,
	psr_out_if.source                     out_ch,
	input  logic                          cfg_write,
	input  logic [psr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psr_pkg::DIM_W-1:0]     cfg_data
);
	import psr_pkg::*;

	psr_cmd_t  cmd;
	psr_stat_t stat;

	psr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_cmd  (in_ch.cmd),
		.in_ready(in_ch.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	psr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.address    (in_ch.address),
		.data       (in_ch.data),
		.aspect_mode(in_ch.aspect_mode),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.pixel      (out_ch.pixel),
		.column     (out_ch.column),
		.row        (out_ch.row),
		.last       (out_ch.last)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench that loads frames and palettes into the renderer and checks every display pixel.
module tb_top;
	import psr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int SETTLE = 100;
	localparam int ITEM_GOAL = 1800;
	localparam int N_FIXED = 10;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
		logic              aspect_mode;
	} request_t;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last;
	} pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	psr_in_if  req_ch();
	psr_out_if pix_ch();

	palette_scale_rotate_renderer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (req_ch),
		.out_ch    (pix_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	int fixed_cols [N_FIXED] = '{3, 0, 2047, 1, 1024, 1025, 4, 2, 1, 7};
	int fixed_rows [N_FIXED] = '{4, 0, 2047, 1024, 1, 5, 20, 9, 2, 3};

	logic [DIM_W-1:0] disp_cols_reg = WIDTH_RESET;
	logic [DIM_W-1:0] disp_rows_reg = HEIGHT_RESET;

	logic [IDX_W-1:0] frame_shadow [FRAME_SIZE];
	logic [PIX_W-1:0] palette_shadow [PALETTE_ENTRIES];
	int unsigned      pix_col, pix_row;
	bit               pix_mode;

	bit               frame_loaded [FRAME_SIZE];
	bit               color_loaded [PALETTE_ENTRIES];
	int unsigned      gen_col, gen_row;
	bit               gen_mode;

	request_t pending[$];
	pixel_t   pixels_due[$];
	request_t current;
	int       items_open;
	int       errors;
	int       n_emit, n_color, n_texel, n_frames, n_black, n_settings;
	bit       calm;
	int       send_gap;
	bit       sending;
	int       stall_left;
	pixel_t   want;

	function automatic int unsigned usable_size(input logic [DIM_W-1:0] v);
		if (v == '0) return 1;
		if (v > 11'd1024) return 1024;
		return v;
	endfunction

	// Nearest-neighbour sample position of a display pixel, rotated clockwise.
	function automatic void locate(input int unsigned cols, input int unsigned rows,
		input int unsigned col, input int unsigned row, input bit aspect,
		output bit black, output int unsigned addr);
		int unsigned sx, sy, band, off;
		black = 1'b0;
		sx = 0;
		sy = ((cols - 1 - col) * SRC_HEIGHT) / cols;
		if (sy >= SRC_HEIGHT) sy = SRC_HEIGHT - 1;
		if (aspect) begin
			band = (cols * SRC_WIDTH) / SRC_HEIGHT;
			if (band > rows) band = rows;
			off = (rows - band) / 2;
			if (band == 0 || row < off || row >= off + band) begin
				black = 1'b1;
			end else begin
				sx = ((row - off) * SRC_WIDTH) / band;
			end
		end else begin
			sx = (row * SRC_WIDTH) / rows;
		end
		if (sx >= SRC_WIDTH) sx = SRC_WIDTH - 1;
		addr = sy * SRC_WIDTH + sx;
	endfunction

	function automatic void advance(input int unsigned cols, input int unsigned rows,
		inout int unsigned col, inout int unsigned row);
		col++;
		if (col >= cols) begin
			col = 0;
			row++;
			if (row >= rows) row = 0;
		end
	endfunction

	function automatic void compare_field(input string name, input int unsigned exp_val,
		input int unsigned got_val);
		if (exp_val != got_val) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
					got_val);
		end
	endfunction

	task automatic render_pixel(input request_t rq);
		int unsigned cols, rows, addr;
		bit          black;
		pixel_t      px;
		cols = usable_size(disp_cols_reg);
		rows = usable_size(disp_rows_reg);
		case (rq.cmd)
			CMD_PAL: begin
				if (rq.address < PALETTE_ENTRIES) palette_shadow[rq.address] = rq.data;
			end
			CMD_PIX: begin
				if (rq.address < FRAME_SIZE) frame_shadow[rq.address] = rq.data[IDX_W-1:0];
			end
			CMD_EMIT: begin
				if (pix_col == 0 && pix_row == 0) pix_mode = rq.aspect_mode;
				locate(cols, rows, pix_col, pix_row, pix_mode, black, addr);
				if (black || frame_shadow[addr] >= PALETTE_ENTRIES) begin
					px.pixel = '0;
				end else begin
					px.pixel = palette_shadow[frame_shadow[addr]];
				end
				px.column = POS_W'(pix_col);
				px.row = POS_W'(pix_row);
				px.last = (pix_col == cols - 1 && pix_row == rows - 1);
				if (black) n_black++;
				if (px.last) n_frames++;
				pixels_due.push_back(px);
				advance(cols, rows, pix_col, pix_row);
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] address,
		input logic [DATA_W-1:0] data, input logic aspect);
		request_t rq;
		rq.cmd = cmd;
		rq.address = address;
		rq.data = data;
		rq.aspect_mode = aspect;
		pending.push_back(rq);
		items_open++;
	endtask

	task automatic load_color(input logic [ADDR_W-1:0] address, input logic [DATA_W-1:0] data);
		queue_request(CMD_PAL, address, data, 1'($urandom));
		if (address < PALETTE_ENTRIES) begin
			color_loaded[address] = 1'b1;
			n_color++;
		end
	endtask

	// Any stored index gets a palette entry first, so no read ever sees an unwritten entry.
	task automatic load_texel(input logic [ADDR_W-1:0] address, input logic [DATA_W-1:0] data);
		if (address < FRAME_SIZE) begin
			if (!color_loaded[data[IDX_W-1:0]])
				load_color(ADDR_W'(data[IDX_W-1:0]), DATA_W'($urandom));
			frame_loaded[address] = 1'b1;
			n_texel++;
		end
		queue_request(CMD_PIX, address, data, 1'($urandom));
	endtask

	task automatic request_pixel(input logic aspect);
		int unsigned cols, rows, addr;
		bit          black;
		cols = usable_size(disp_cols_reg);
		rows = usable_size(disp_rows_reg);
		if (gen_col == 0 && gen_row == 0) gen_mode = aspect;
		locate(cols, rows, gen_col, gen_row, gen_mode, black, addr);
		if (!black && (!frame_loaded[addr] || $urandom_range(0, 3) == 0))
			load_texel(ADDR_W'(addr), DATA_W'($urandom));
		queue_request(CMD_EMIT, ADDR_W'($urandom), DATA_W'($urandom), aspect);
		n_emit++;
		advance(cols, rows, gen_col, gen_row);
	endtask

	task automatic random_burst(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				request_pixel(1'($urandom));
			end else if (pick < 72) begin
				load_texel(($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
					: ADDR_W'($urandom_range(0, FRAME_SIZE - 1)), DATA_W'($urandom));
			end else if (pick < 92) begin
				load_color(($urandom_range(0, 4) == 0) ? ADDR_W'($urandom)
					: ADDR_W'($urandom_range(0, PALETTE_ENTRIES - 1)), DATA_W'($urandom));
			end else begin
				queue_request(CMD_NONE, ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic wait_idle();
		while (items_open != 0 || pixels_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_WIDTH) begin
			disp_cols_reg = value;
		end else begin
			disp_rows_reg = value;
		end
		pix_col = 0;
		pix_row = 0;
		gen_col = 0;
		gen_row = 0;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			sending = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				render_pixel(current);
				items_open--;
				sending = 1'b0;
				if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 17);
			end
			if (!sending) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending.size() != 0) begin
					current = pending.pop_front();
					sending = 1'b1;
				end
			end
			req_ch.valid <= sending;
			req_ch.cmd <= current.cmd;
			req_ch.address <= current.address;
			req_ch.data <= current.data;
			req_ch.aspect_mode <= current.aspect_mode;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pix_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				if (pixels_due.size() == 0) begin
					errors++;
					if (errors <= 40)
						$display("%0t: unexpected pixel, expected none, actual %0h at %0d,%0d",
							$time, pix_ch.pixel, pix_ch.column, pix_ch.row);
				end else begin
					want = pixels_due.pop_front();
					compare_field("pixel", want.pixel, pix_ch.pixel);
					compare_field("column", want.column, pix_ch.column);
					compare_field("row", want.row, pix_ch.row);
					compare_field("last", want.last, pix_ch.last);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			pix_ch.ready <= (stall_left == 0);
		end
	end

	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int phase;
		int cols_val, rows_val;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_PAL;
		req_ch.address = '0;
		req_ch.data = '0;
		req_ch.aspect_mode = 1'b0;
		pix_ch.ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		current = '{default: '0};
		items_open = 0;
		errors = 0;
		n_settings = 1;
		calm = 1'b0;
		pix_col = 0;
		pix_row = 0;
		pix_mode = 1'b0;
		gen_col = 0;
		gen_row = 0;
		gen_mode = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Store extremes, ignored addresses, the unused command, then a frame start in aspect mode.
		load_color(ADDR_W'(0), 16'h0000);
		load_color(ADDR_W'(PALETTE_ENTRIES - 1), 16'hFFFF);
		load_color(ADDR_W'(PALETTE_ENTRIES), 16'h1234);
		load_color(16'hFFFF, 16'hA5A5);
		load_texel(ADDR_W'(0), 16'hFF00);
		load_texel(ADDR_W'(FRAME_SIZE - 1), 16'h00FF);
		load_texel(ADDR_W'(FRAME_SIZE), 16'h5A5A);
		load_texel(16'hFFFF, 16'hFFFF);
		queue_request(CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b1);
		request_pixel(1'b1);
		request_pixel(1'b0);
		request_pixel(1'b0);
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_WIDTH, 11'd2);
		write_reg(REG_HEIGHT, 11'd2);
		request_pixel(1'b0);
		request_pixel(1'b1);
		request_pixel(1'b1);
		request_pixel(1'b1);
		request_pixel(1'b1);
		request_pixel(1'b0);
		queue_request(CMD_NONE, 16'h0000, 16'h0000, 1'b0);
		request_pixel(1'b0);
		random_burst(100);

		phase = 0;
		while (n_emit + n_color + n_texel < ITEM_GOAL) begin
			wait_idle();
			repeat (SETTLE) @(posedge clk);
			if (phase < N_FIXED) begin
				cols_val = fixed_cols[phase];
				rows_val = fixed_rows[phase];
			end else if ($urandom_range(0, 7) == 0) begin
				cols_val = $urandom_range(0, 2047);
				rows_val = $urandom_range(0, 2047);
			end else begin
				cols_val = $urandom_range(1, 24);
				rows_val = $urandom_range(1, 40);
			end
			if (phase >= N_FIXED && phase % 5 == 2) begin
				if ($urandom_range(0, 1) == 1) begin
					write_reg(REG_WIDTH, DIM_W'(cols_val));
				end else begin
					write_reg(REG_HEIGHT, DIM_W'(rows_val));
				end
			end else begin
				write_reg(REG_WIDTH, DIM_W'(cols_val));
				write_reg(REG_HEIGHT, DIM_W'(rows_val));
			end
			calm = (phase % 4 == 3) || (n_emit + n_color + n_texel > ITEM_GOAL - 200);
			random_burst(120);
			phase++;
			n_settings++;
		end

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d display pixels after %0d palette and %0d frame writes, %0d settings.",
			n_emit, n_color, n_texel, n_settings);
		$display("%0d frames ran to their last pixel and %0d pixels fell in black bars.",
			n_frames, n_black);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
